@@ src/first_fit_block_allocator_defines.svh @@
// Assertion macros for the first-fit block allocator.
// Depends on nothing; included by the top level.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FFA_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FFA_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define FFA_ASSERT_IMP(label, a, c)
`define FFA_ASSERT_NXT(label, a, c)
`endif
`endif

@@ src/ffa_pkg.sv @@
// Shared types and codes for the first-fit block allocator.
// No dependencies.
package ffa_pkg;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;
  localparam int SIZE_W = 21;
  localparam int OFF_W  = 20;
  localparam int CFG_ARENA_LIMIT = 0;
  localparam logic [SIZE_W-1:0] ARENA_LIMIT_RST = 21'h100000;
endpackage

@@ src/first_fit_block_allocator.sv @@
// First-fit block allocator, top level.
// Uses ffa_pkg, ffa_table and first_fit_block_allocator_defines.svh.
//
// Requests arrive on in_* (tuser = operation, tdata = request_bytes then
// payload_offset_in). One result per request leaves on out_* (tdata =
// payload_offset then status). arena_limit is written over cfg_* (addr 0).
// The table is one memory with a registered read; a sequencer walks it one
// entry at a time (read, then use). A split shifts entries up (read, then
// write each one), and a free that finds its block adds a merge pass over
// all entries (read, check, then an insert step). One request is walked at a time.
// The result is held in an output register, and the next request is
// taken while it waits; a stalled receiver holds the result, and the request
// behind it finishes its walk and then waits, which blocks new requests.
// Reset empties the table (count and break pointer to zero), no clearing
// pass is needed.
`include "first_fit_block_allocator_defines.svh"
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS      = 64,
  parameter int ARENA_ADDR_BITS = 20,
  parameter int HEADER_BYTES    = 16,
  parameter int ALIGN_BYTES     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // request_bytes[20:0], payload_offset_in[40:21]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // payload_offset[19:0], status[21:20]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ffa_pkg::*;
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int W  = 34;
  localparam logic [W-1:0] HDR = W'(HEADER_BYTES);
  localparam logic [W-1:0] ALN = W'(ALIGN_BYTES);
  localparam logic [W-1:0] CAP = W'(1) << ARENA_ADDR_BITS;
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_CHK = 4'd2,
    S_SHR = 4'd3, S_SHW = 4'd4, S_MRD = 4'd5, S_MCHK = 4'd6,
    S_OUT = 4'd7, S_RND = 4'd8, S_INS = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [SIZE_W-1:0] limit_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [W-1:0]  brk_r, brk_nxt;
  logic          op_r;
  logic [SIZE_W-1:0] req_r;
  logic [OFF_W-1:0]  addr_r;
  logic [W-1:0]  asize_r, asize_nxt, start_r, start_nxt, sz_r, sz_nxt;
  logic [CW-1:0] i_r, i_nxt, k_r, k_nxt, w_r, w_nxt;
  logic          wfree_r, wfree_nxt;
  logic [SIZE_W-1:0] wsize_r, wsize_nxt;
  logic          ov_r, ov_nxt;
  logic [OFF_W-1:0] ooff_r, ooff_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [OFF_W-1:0] res_off_r;
  logic [1:0]    res_st_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [SIZE_W:0] wdata, rdata;
  logic [SIZE_W-1:0] rsz;
  logic rfree;

  ffa_table #(.DEPTH(MAX_BLOCKS), .AW(AW)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  assign rsz   = rdata[SIZE_W-1:0];
  assign rfree = rdata[SIZE_W];

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-SIZE_W){1'b0}}, limit_r};
  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= ARENA_LIMIT_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'(CFG_ARENA_LIMIT*4))
      limit_r <= cfg_pwdata[SIZE_W-1:0];
  end

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, res_st_r, res_off_r};

  logic [W-1:0] lim, sumb;
  assign lim  = ({13'b0, limit_r} < CAP) ? {13'b0, limit_r} : CAP;
  assign sumb = brk_r + HDR + asize_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; brk_nxt = brk_r;
    asize_nxt = asize_r; start_nxt = start_r; sz_nxt = sz_r;
    i_nxt = i_r; k_nxt = k_r; w_nxt = w_r; wfree_nxt = wfree_r; wsize_nxt = wsize_r;
    ov_nxt = ov_r; ooff_nxt = ooff_r; ost_nxt = ost_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = i_r[AW-1:0];
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        state_nxt = S_RND; i_nxt = '0; start_nxt = '0;
      end
      S_RND: begin
        asize_nxt = (({13'b0, req_r} + ALN - W'(1)) / ALN) * ALN;
        if (op_r == OP_ALLOC && req_r == '0) begin
          ooff_nxt = '0; ost_nxt = ST_ZERO; state_nxt = S_OUT;
        end else state_nxt = S_RD;
      end
      S_RD: begin
        if (i_r >= count_r) begin
          state_nxt = S_OUT; ooff_nxt = '0;
          if (op_r == OP_FREE) ost_nxt = ST_UNKNOWN;
          else if (count_r >= MAXC || sumb > lim) ost_nxt = ST_OOM;
          else begin
            we = 1'b1; waddr = count_r[AW-1:0]; wdata = {1'b0, asize_r[SIZE_W-1:0]};
            count_nxt = count_r + CW'(1);
            ooff_nxt = OFF_W'(brk_r + HDR); ost_nxt = ST_OK;
            brk_nxt = {13'b0, sumb[SIZE_W-1:0]};
          end
        end else begin
          raddr = i_r[AW-1:0]; state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        sz_nxt = {13'b0, rsz};
        if (op_r == OP_FREE) begin
          if (start_r + HDR == {14'b0, addr_r}) begin
            we = 1'b1; waddr = i_r[AW-1:0]; wdata = {1'b1, rsz};
            ooff_nxt = '0; ost_nxt = ST_OK;
            k_nxt = '0; w_nxt = '0; state_nxt = S_MRD;
          end else begin
            start_nxt = start_r + HDR + {13'b0, rsz};
            i_nxt = i_r + CW'(1); state_nxt = S_RD;
          end
        end else if (rfree && {13'b0, rsz} >= asize_r) begin
          ooff_nxt = OFF_W'(start_r + HDR); ost_nxt = ST_OK;
          we = 1'b1; waddr = i_r[AW-1:0];
          if ({13'b0, rsz} > asize_r + HDR + HDR + ALN && count_r < MAXC) begin
            wdata = {1'b0, asize_r[SIZE_W-1:0]};
            k_nxt = count_r; state_nxt = S_SHR;
          end else begin
            wdata = {1'b0, rsz}; state_nxt = S_OUT;
          end
        end else begin
          start_nxt = start_r + HDR + {13'b0, rsz};
          i_nxt = i_r + CW'(1); state_nxt = S_RD;
        end
      end
      S_SHR: begin
        if (k_r > i_r + CW'(1)) begin
          raddr = AW'(k_r - CW'(1)); state_nxt = S_SHW;
        end else begin
          we = 1'b1; waddr = AW'(i_r + CW'(1));
          wdata = {1'b1, SIZE_W'(sz_r - asize_r - HDR)};
          count_nxt = count_r + CW'(1); state_nxt = S_OUT;
        end
      end
      S_SHW: begin
        we = 1'b1; waddr = k_r[AW-1:0]; wdata = rdata;
        k_nxt = k_r - CW'(1); state_nxt = S_SHR;
      end
      S_MRD: begin
        if (k_r >= count_r) begin
          if (w_r != '0) begin
            we = 1'b1; waddr = AW'(w_r - CW'(1)); wdata = {wfree_r, wsize_r};
          end
          count_nxt = w_r; state_nxt = S_OUT;
        end else begin
          raddr = k_r[AW-1:0]; state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        k_nxt = k_r + CW'(1); state_nxt = S_INS;
        if (w_r != '0 && wfree_r && rfree)
          wsize_nxt = SIZE_W'({13'b0, wsize_r} + HDR + {13'b0, rsz});
        else begin
          if (w_r != '0) begin
            we = 1'b1; waddr = AW'(w_r - CW'(1)); wdata = {wfree_r, wsize_r};
          end
          wfree_nxt = rfree; wsize_nxt = rsz; w_nxt = w_r + CW'(1);
        end
      end
      S_INS: state_nxt = S_MRD;
      S_OUT: if (!ov_r || out_tready) begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; brk_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; brk_r <= brk_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tuser; req_r <= in_tdata[20:0]; addr_r <= in_tdata[40:21];
    end
    if (state_r == S_OUT && (!ov_r || out_tready)) begin
      res_off_r <= ooff_r; res_st_r <= ost_r;
    end
    asize_r <= asize_nxt; start_r <= start_nxt; sz_r <= sz_nxt;
    i_r <= i_nxt; k_r <= k_nxt; w_r <= w_nxt;
    wfree_r <= wfree_nxt; wsize_r <= wsize_nxt;
    ooff_r <= ooff_nxt; ost_r <= ost_nxt;
  end

  `FFA_ASSERT_IMP(a_count_max, 1'b1, count_r <= MAXC)
  `FFA_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_tready)
  `FFA_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `FFA_ASSERT_IMP(a_off_zero, out_tvalid && res_st_r != ST_OK, res_off_r == '0)
endmodule

@@ src/ffa_table.sv @@
// Block table memory: one synchronous-read array of size and free mark.
// Depends on ffa_pkg.
module ffa_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ffa_pkg::SIZE_W:0]  wdata,
  input  logic [AW-1:0]             raddr,
  output logic [ffa_pkg::SIZE_W:0]  rdata
);
  import ffa_pkg::*;
  logic [SIZE_W:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for first_fit_block_allocator: directed table, then random
// alloc/free traffic checked against an in-bench model of the block table.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module testbench;
  import ffa_pkg::*;

  localparam int NBLK = 64;
  localparam int HDR = 16;
  localparam int ALN = 8;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic op;
    logic [SIZE_W-1:0] bytes;
    logic [OFF_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [1:0] st;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tready, in_tuser = 0;
  logic [47:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0;
  logic [23:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;

  first_fit_block_allocator dut (.*);

  always #1 clk = ~clk;

  // model state
  longint m_size[NBLK];
  bit m_free[NBLK];
  int m_count;
  longint m_brk;
  longint m_limit;

  res_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle = 6, recv_idle = 57;
  bit hold_recv = 0;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void merge_runs();
    int w;
    w = 0;
    for (int r = 0; r < m_count; r++) begin
      if (w > 0 && m_free[w-1] && m_free[r]) begin
        m_size[w-1] = (m_size[w-1] + HDR + m_size[r]) & 21'h1FFFFF;
      end else begin
        m_size[w] = m_size[r];
        m_free[w] = m_free[r];
        w++;
      end
    end
    m_count = w;
  endfunction

  function automatic res_t predict_alloc(longint req);
    res_t r;
    longint asz, start, sz, lim;
    r = '0;
    if (req == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    asz = ((req + ALN - 1) / ALN) * ALN;
    start = 0;
    for (int i = 0; i < m_count; i++) begin
      sz = m_size[i];
      if (m_free[i] && sz >= asz) begin
        if (sz > asz + 2*HDR + ALN && m_count < NBLK) begin
          m_size[i] = asz;
          for (int k = m_count; k > i + 1; k--) begin
            m_size[k] = m_size[k-1];
            m_free[k] = m_free[k-1];
          end
          m_size[i+1] = sz - asz - HDR;
          m_free[i+1] = 1;
          m_count++;
        end
        m_free[i] = 0;
        r.off = OFF_W'(start + HDR);
        r.st = ST_OK;
        return r;
      end
      start += HDR + sz;
    end
    lim = m_limit < (1 << 20) ? m_limit : (1 << 20);
    if (m_count >= NBLK || m_brk + HDR + asz > lim) begin
      r.st = ST_OOM;
      return r;
    end
    m_size[m_count] = asz & 21'h1FFFFF;
    m_free[m_count] = 0;
    m_count++;
    r.off = OFF_W'(m_brk + HDR);
    m_brk = (m_brk + HDR + asz) & 21'h1FFFFF;
    r.st = ST_OK;
    return r;
  endfunction

  function automatic res_t predict_free(longint a);
    res_t r;
    longint start;
    r = '0;
    start = 0;
    for (int i = 0; i < m_count; i++) begin
      if (start + HDR == a) begin
        m_free[i] = 1;
        merge_runs();
        r.st = ST_OK;
        return r;
      end
      start += HDR + m_size[i];
    end
    r.st = ST_UNKNOWN;
    return r;
  endfunction

  function automatic res_t predict_allocator(req_t q);
    if (q.op == OP_ALLOC) return predict_alloc(longint'(q.bytes));
    return predict_free(longint'(q.addr));
  endfunction

  // pick a live payload offset most of the time
  function automatic logic [OFF_W-1:0] pick_offset();
    longint start;
    int n;
    n = $urandom_range(0, m_count > 0 ? m_count - 1 : 0);
    start = 0;
    for (int i = 0; i < n; i++) start += HDR + m_size[i];
    return OFF_W'(start + HDR);
  endfunction

  task automatic send(req_t q, bit typed, res_t want);
    res_t p;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    p = predict_allocator(q);
    if (typed && p != want) report("directed row", longint'(p), longint'(want));
    expected_q.push_back(p);
    in_tvalid <= 1;
    in_tuser <= q.op;
    in_tdata <= {7'd0, q.addr, q.bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= 2'(CFG_ARENA_LIMIT * 4); cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    m_limit = v & 21'h1FFFFF;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    req_t q;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      q.bytes = SIZE_W'($urandom());
      q.addr = OFF_W'($urandom());
      if (k < 50) begin
        q.op = OP_ALLOC;
        q.bytes = SIZE_W'($urandom_range(1, 200));
        if ($urandom_range(0, 19) == 0) q.bytes = SIZE_W'($urandom_range(0, 21'h1FFFFF));
        if ($urandom_range(0, 29) == 0) q.bytes = '0;
      end else begin
        q.op = OP_FREE;
        if (k > 92) q.addr = OFF_W'($urandom_range(0, 20'hFFFFF));
        else q.addr = pick_offset();
      end
      send(q, 1'b0, '0);
    end
  endtask

  // receiver
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[19:0], out_tdata[21:20]};
        if (expected_q.size() == 0) begin
          report("unexpected result", longint'(got), 0);
        end else begin
          want = expected_q.pop_front();
          if (got.off != want.off) report("payload_offset", longint'(got.off),
                                           longint'(want.off));
          if (got.st != want.st) report("status", longint'(got.st), longint'(want.st));
        end
      end
      out_tready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_block_allocator verification failed");
      $finish;
    end
  end

  // hold off the receiver for a long stretch while requests are offered
  initial begin
    wait (cycles > 2000 && in_tvalid);
    hold_recv = 1;
    repeat (3000) @(posedge clk);
    hold_recv = 0;
  end

  initial begin
    req_t dir[$];
    res_t dres[$];
    bit dtyp[$];
    m_limit = ARENA_LIMIT_RST; m_count = 0; m_brk = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // op, bytes, addr | typed, expected off/status
    dir = '{'{OP_FREE, 21'd0, 20'd16}, '{OP_ALLOC, 21'd0, 20'd0},
            '{OP_ALLOC, 21'd1, 20'hFFFFF}, '{OP_ALLOC, 21'd100, 20'd0},
            '{OP_ALLOC, 21'd8, 20'd0}, '{OP_FREE, 21'h1FFFFF, 20'd40},
            '{OP_ALLOC, 21'd40, 20'd0}, '{OP_FREE, 21'd0, 20'd40},
            '{OP_FREE, 21'd0, 20'd40}, '{OP_FREE, 21'd0, 20'd16},
            '{OP_ALLOC, 21'd24, 20'd0}, '{OP_ALLOC, 21'h1FFFFF, 20'd0},
            '{OP_ALLOC, 21'h100000, 20'd0}, '{OP_FREE, 21'd0, 20'hFFFFF},
            '{OP_ALLOC, 21'd7, 20'd0}};
    dres = '{'{20'd0, ST_UNKNOWN}, '{20'd0, ST_ZERO}, '{20'd16, ST_OK},
             '{20'd0, ST_OK}, '{20'd0, ST_OK}, '{20'd0, ST_OK}, '{20'd0, ST_OK},
             '{20'd0, ST_OK}, '{20'd0, ST_OK}, '{20'd0, ST_OK}, '{20'd0, ST_OK},
             '{20'd0, ST_OOM}, '{20'd0, ST_OOM}, '{20'd0, ST_UNKNOWN}, '{20'd0, ST_OK}};
    dtyp = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
             1'b1, 1'b1, 1'b1, 1'b0};
    foreach (dir[i]) send(dir[i], dtyp[i], dres[i]);
    drain();
    random_phase(250);
    drain();
    write_limit(32'd600);
    send_idle = 57; recv_idle = 6;
    random_phase(150);
    drain();
    write_limit(32'd0);
    random_phase(40);
    drain();
    write_limit(32'h1FFFFF);
    send_idle = 0; recv_idle = 0;
    random_phase(260);
    drain();
    write_limit(32'h100000);
    random_phase(20);
    drain();
    if (errors == 0 && expected_q.size() == 0)
      $display("first_fit_block_allocator verification clean");
    else
      $display("first_fit_block_allocator verification failed");
    $finish;
  end
endmodule
